// ===== rtl/core/mbrot_pkg.sv =====
package mbrot_pkg;

    // Widths of the pixel position fields and of the iteration limit.
    localparam int unsigned ROW_W  = 10;
    localparam int unsigned COL_W  = 11;
    localparam int unsigned ITER_W = 16;

    // Image size that the step constants of the coordinate mapping are derived from.
    localparam int unsigned IMAGE_WIDTH  = 1400;
    localparam int unsigned IMAGE_HEIGHT = 800;

    // Iteration limit after reset.
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd1000;

    // Which product the shared multiplier is forming.
    typedef enum logic [1:0] {
        OP_XX,
        OP_YY,
        OP_XY
    } t_mul_op;

endpackage

// ===== rtl/core/mandelbrot_membership_test.sv =====
// Mandelbrot membership test for one pixel.
// Command channel: drive i_row and i_col with start high; the word is taken at the
// rising edge at which start is high and busy is low. busy then stays high until
// the result has been produced.
// Result channel: o_result_valid is high for exactly one cycle with o_row_out,
// o_col_out and o_in_set. The receiver cannot stall it, and a new command may be
// issued in the very cycle the result is shown.
// Configuration channel: i_cfg_data is the iteration limit, written when
// i_cfg_valid and o_cfg_ready are both high; o_cfg_ready is high while idle.
// Timing: one shared multiplier forms x*x, y*y and 2*x*y in turn. It makes one
// partial product per cycle: one pass for fraction widths up to 30 bits, four
// passes above. Each iteration tests z, forms x*x and y*y, compares |z|^2 with
// four, forms 2*x*y and then updates z. The next command can be taken at the edge
// that ends the result cycle.
// Reset (synchronous, active low) returns the block to idle, drops any pixel in
// progress and sets the iteration limit to 1000.
module mandelbrot_membership_test #(
    parameter int unsigned FRACTION_BITS = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mbrot_pkg::ROW_W-1:0]   i_row,
    input  logic [mbrot_pkg::COL_W-1:0]   i_col,
    output logic                          o_result_valid,
    output logic [mbrot_pkg::ROW_W-1:0]   o_row_out,
    output logic [mbrot_pkg::COL_W-1:0]   o_col_out,
    output logic                          o_in_set,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mbrot_pkg::ITER_W-1:0]  i_cfg_data
);

    // Widths: z components, operand magnitudes, multiplier limbs, mapping.
    localparam int unsigned W     = FRACTION_BITS + 6;
    localparam int unsigned M     = FRACTION_BITS + 2;
    localparam int unsigned LIMBS = (M <= 32) ? 1 : 2;
    localparam int unsigned LW    = (M + LIMBS - 1) / LIMBS;
    localparam int unsigned PADW  = LIMBS * LW;
    localparam int unsigned AW    = 2 * PADW;
    localparam int unsigned NPART = LIMBS * LIMBS;
    localparam int unsigned PCW   = $clog2(NPART + 1);
    localparam int unsigned CW    = FRACTION_BITS + 15;

    // Step constants, rounded half up.
    localparam logic [63:0] STEP_RE_64 =
        ((64'd7 << FRACTION_BITS) + 64'(mbrot_pkg::IMAGE_WIDTH - 1))
        / 64'(2 * (mbrot_pkg::IMAGE_WIDTH - 1));
    localparam logic [63:0] STEP_IM_64 =
        ((64'd4 << FRACTION_BITS) + 64'(mbrot_pkg::IMAGE_HEIGHT - 1))
        / 64'(2 * (mbrot_pkg::IMAGE_HEIGHT - 1));
    localparam logic [CW-1:0] STEP_RE = STEP_RE_64[CW-1:0];
    localparam logic [CW-1:0] STEP_IM = STEP_IM_64[CW-1:0];
    localparam logic [CW-1:0] ONE_C   = CW'(1) << FRACTION_BITS;
    localparam logic [CW-1:0] OFF_RE  = (ONE_C << 1) + (ONE_C >> 1);
    localparam logic [CW-1:0] C_HI    = (ONE_C << 3) - CW'(1);
    localparam logic [CW-1:0] C_LO    = ~(ONE_C << 3) + CW'(1);
    localparam logic [W:0]    FOUR    = (W + 1)'(1) << (FRACTION_BITS + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_TEST,
        S_MUL,
        S_FIN,
        S_CMP,
        S_UPD
    } t_state;

    t_state                          r_state, n_state;
    mbrot_pkg::t_mul_op              r_op, n_op;
    logic [mbrot_pkg::ROW_W-1:0]     r_row, n_row;
    logic [mbrot_pkg::COL_W-1:0]     r_col, n_col;
    logic [mbrot_pkg::ITER_W-1:0]    r_max, n_max;
    logic [mbrot_pkg::ITER_W-1:0]    r_cnt, n_cnt;
    logic signed [W-1:0]             r_cr, n_cr;
    logic signed [W-1:0]             r_ci, n_ci;
    logic signed [W-1:0]             r_x, n_x;
    logic signed [W-1:0]             r_y, n_y;
    logic signed [W-1:0]             r_xx, n_xx;
    logic signed [W-1:0]             r_yy, n_yy;
    logic signed [W-1:0]             r_xy, n_xy;
    logic [M-1:0]                    r_ma, n_ma;
    logic [M-1:0]                    r_mb, n_mb;
    logic                            r_neg, n_neg;
    logic [PCW-1:0]                  r_step, n_step;
    logic [2*LW-1:0]                 r_pp, n_pp;
    logic [1:0]                      r_pp_pos, n_pp_pos;
    logic [AW-1:0]                   r_acc, n_acc;
    logic                            r_valid, n_valid;
    logic                            r_in_set, n_in_set;

    logic [W-1:0]      abs_x, abs_y;
    logic              x_big, y_big;
    logic [PADW-1:0]   pad_a, pad_b;
    logic [LW-1:0]     limb_a, limb_b;
    logic [AW:0]       acc_ext, acc_sgn;
    logic signed [AW:0] prod_full;
    logic signed [W-1:0] prod;
    logic [W:0]        mag_sum;
    logic [CW-1:0]     cr_wide, ci_wide;
    logic signed [W-1:0] cr_sat, ci_sat;

    // Magnitudes of z and the early escape check: |x| >= 2 or |y| >= 2.
    always_comb begin
        abs_x = r_x[W-1] ? W'(-r_x) : W'(r_x);
        abs_y = r_y[W-1] ? W'(-r_y) : W'(r_y);
        x_big = |abs_x[W-1:FRACTION_BITS+1];
        y_big = |abs_y[W-1:FRACTION_BITS+1];
    end

    // Limb selection for the partial product of this pass.
    always_comb begin
        pad_a  = PADW'(r_ma);
        pad_b  = PADW'(r_mb);
        limb_a = LW'(pad_a >> (LW * (r_step / LIMBS)));
        limb_b = LW'(pad_b >> (LW * (r_step % LIMBS)));
    end

    // Signed result of the finished product, floored after the fraction shift.
    always_comb begin
        acc_ext   = {1'b0, r_acc};
        acc_sgn   = r_neg ? (~acc_ext + (AW + 1)'(1)) : acc_ext;
        prod_full = $signed(acc_sgn) >>> FRACTION_BITS;
        prod      = $signed(prod_full[W-1:0]);
        mag_sum   = {1'b0, r_xx} + {1'b0, r_yy};
    end

    // Pixel to complex plane, saturated to the c range.
    always_comb begin
        cr_wide = (CW'(r_col) * STEP_RE) - OFF_RE;
        ci_wide = (CW'(r_row) * STEP_IM) - ONE_C;
        if ($signed(cr_wide) > $signed(C_HI)) begin
            cr_sat = $signed(C_HI[W-1:0]);
        end else if ($signed(cr_wide) < $signed(C_LO)) begin
            cr_sat = $signed(C_LO[W-1:0]);
        end else begin
            cr_sat = $signed(cr_wide[W-1:0]);
        end
        if ($signed(ci_wide) > $signed(C_HI)) begin
            ci_sat = $signed(C_HI[W-1:0]);
        end else if ($signed(ci_wide) < $signed(C_LO)) begin
            ci_sat = $signed(C_LO[W-1:0]);
        end else begin
            ci_sat = $signed(ci_wide[W-1:0]);
        end
    end

    // Sequencer: next values of all registers.
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_row    = r_row;
        n_col    = r_col;
        n_max    = r_max;
        n_cnt    = r_cnt;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_x      = r_x;
        n_y      = r_y;
        n_xx     = r_xx;
        n_yy     = r_yy;
        n_xy     = r_xy;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_neg    = r_neg;
        n_step   = r_step;
        n_pp     = r_pp;
        n_pp_pos = r_pp_pos;
        n_acc    = r_acc;
        n_valid  = 1'b0;
        n_in_set = r_in_set;

        if (i_cfg_valid && o_cfg_ready) begin
            n_max = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_row   = i_row;
                    n_col   = i_col;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_cr    = cr_sat;
                n_ci    = ci_sat;
                n_x     = '0;
                n_y     = '0;
                n_cnt   = '0;
                n_state = S_TEST;
            end
            S_TEST: begin
                // Limit reached, or z already outside the radius-two box.
                if (r_cnt >= r_max) begin
                    n_valid  = 1'b1;
                    n_in_set = 1'b1;
                    n_state  = S_IDLE;
                end else if (x_big || y_big) begin
                    n_valid  = 1'b1;
                    n_in_set = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    n_op    = mbrot_pkg::OP_XX;
                    n_ma    = M'(abs_x);
                    n_mb    = M'(abs_x);
                    n_neg   = 1'b0;
                    n_step  = '0;
                    n_acc   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // One partial product a pass, registered and accumulated in the next cycle.
                n_pp     = limb_a * limb_b;
                n_pp_pos = 2'((r_step / LIMBS) + (r_step % LIMBS));
                if (r_step != '0) begin
                    n_acc = r_acc + (AW'(r_pp) << (LW * r_pp_pos));
                end
                if (r_step == PCW'(NPART)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + PCW'(1);
                end
            end
            S_FIN: begin
                unique case (r_op)
                    mbrot_pkg::OP_XX: begin
                        n_xx    = prod;
                        n_op    = mbrot_pkg::OP_YY;
                        n_ma    = M'(abs_y);
                        n_mb    = M'(abs_y);
                        n_neg   = 1'b0;
                        n_step  = '0;
                        n_acc   = '0;
                        n_state = S_MUL;
                    end
                    mbrot_pkg::OP_YY: begin
                        n_yy    = prod;
                        n_state = S_CMP;
                    end
                    mbrot_pkg::OP_XY: begin
                        n_xy    = prod;
                        n_state = S_UPD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CMP: begin
                // Escape when |z|^2 reaches four, else form 2*x*y.
                if (mag_sum >= FOUR) begin
                    n_valid  = 1'b1;
                    n_in_set = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    n_op    = mbrot_pkg::OP_XY;
                    n_ma    = {abs_x[M-2:0], 1'b0};
                    n_mb    = M'(abs_y);
                    n_neg   = r_x[W-1] ^ r_y[W-1];
                    n_step  = '0;
                    n_acc   = '0;
                    n_state = S_MUL;
                end
            end
            S_UPD: begin
                n_x     = r_xx - r_yy + r_cr;
                n_y     = r_xy + r_ci;
                n_cnt   = r_cnt + mbrot_pkg::ITER_W'(1);
                n_state = S_TEST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= mbrot_pkg::OP_XX;
            r_max    <= mbrot_pkg::MAX_ITER_RESET;
            r_cnt    <= '0;
            r_step   <= '0;
            r_valid  <= 1'b0;
            r_in_set <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_max    <= n_max;
            r_cnt    <= n_cnt;
            r_step   <= n_step;
            r_valid  <= n_valid;
            r_in_set <= n_in_set;
            r_row    <= n_row;
            r_col    <= n_col;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cr     <= n_cr;
        r_ci     <= n_ci;
        r_x      <= n_x;
        r_y      <= n_y;
        r_xx     <= n_xx;
        r_yy     <= n_yy;
        r_xy     <= n_xy;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_neg    <= n_neg;
        r_pp     <= n_pp;
        r_pp_pos <= n_pp_pos;
        r_acc    <= n_acc;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_result_valid = r_valid;
    assign o_in_set       = r_in_set;
    assign o_row_out      = r_row;
    assign o_col_out      = r_col;

    // A taken command always leaves the idle state.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy");

    // A result is produced only on the way back to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while still busy");

    // The iteration count never passes the limit during a pixel.
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_state != S_MAP) |-> (r_cnt <= r_max))
        else $error("iteration count above limit");

    // The pass counter stays within the partial products of one multiplication.
    a_pass_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step <= PCW'(NPART)))
        else $error("multiplier pass counter out of range");

endmodule

// ===== tb/mandelbrot_membership_test_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, result and limit channels of the membership test.
// It keeps its own copy of the iteration limit, predicts the result of every
// pixel that is taken, and compares the results in order of arrival.
module mandelbrot_membership_test_checker #(
    parameter int unsigned FRACTION_BITS = 28
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic [mbrot_pkg::ROW_W-1:0]         i_row,
    input  logic [mbrot_pkg::COL_W-1:0]         i_col,
    input  logic                                i_result_valid,
    input  logic [mbrot_pkg::ROW_W-1:0]         i_row_out,
    input  logic [mbrot_pkg::COL_W-1:0]         i_col_out,
    input  logic                                i_in_set,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [mbrot_pkg::ITER_W-1:0]        i_cfg_data,
    output int unsigned                         o_fail_count,
    output int unsigned                         o_pending,
    output int unsigned                         o_pixels,
    output int unsigned                         o_results,
    output int unsigned                         o_inside
);

    // Local names for the shared widths and image size.
    localparam int unsigned ROW_W        = mbrot_pkg::ROW_W;
    localparam int unsigned COL_W        = mbrot_pkg::COL_W;
    localparam int unsigned ITER_W       = mbrot_pkg::ITER_W;
    localparam int unsigned IMAGE_WIDTH  = mbrot_pkg::IMAGE_WIDTH;
    localparam int unsigned IMAGE_HEIGHT = mbrot_pkg::IMAGE_HEIGHT;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = mbrot_pkg::MAX_ITER_RESET;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             in_set;
    } t_pixel_verdict;

    localparam longint ONE_FX = longint'(1) << FRACTION_BITS;
    localparam longint C_HIGH = 8 * ONE_FX - 1;
    localparam longint C_LOW  = -8 * ONE_FX;

    t_pixel_verdict        awaited_verdicts[$];
    logic [ITER_W-1:0]     iter_limit;

    // Full-width signed product, scaled back by the fraction bits with flooring.
    function automatic longint scaled_product(input longint a, input longint b);
        logic signed [127:0] wide_a;
        logic signed [127:0] wide_b;
        logic signed [127:0] wide_p;
        wide_a = a;
        wide_b = b;
        wide_p = wide_a * wide_b;
        return longint'(wide_p >>> FRACTION_BITS);
    endfunction

    // Clamps one component of c to the range that four integer bits can hold.
    function automatic longint clamp_coord(input longint v);
        if (v > C_HIGH) begin
            return C_HIGH;
        end
        if (v < C_LOW) begin
            return C_LOW;
        end
        return v;
    endfunction

    // Iterates z = z*z + c from zero and reports whether the limit is reached
    // before the squared magnitude gets to four.
    function automatic logic stays_bounded(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col,
                                           input logic [ITER_W-1:0] limit);
        longint      step_re;
        longint      step_im;
        longint      c_re;
        longint      c_im;
        longint      x;
        longint      y;
        longint      xx;
        longint      yy;
        longint      next_y;
        int unsigned count;
        step_re = ((longint'(7) << FRACTION_BITS) + longint'(IMAGE_WIDTH - 1))
                  / longint'(2 * (IMAGE_WIDTH - 1));
        step_im = ((longint'(4) << FRACTION_BITS) + longint'(IMAGE_HEIGHT - 1))
                  / longint'(2 * (IMAGE_HEIGHT - 1));
        c_re  = clamp_coord(longint'(col) * step_re - 5 * (ONE_FX / 2));
        c_im  = clamp_coord(longint'(row) * step_im - ONE_FX);
        x     = 0;
        y     = 0;
        count = 0;
        while (count < limit) begin
            xx = scaled_product(x, x);
            yy = scaled_product(y, y);
            if (xx + yy >= 4 * ONE_FX) begin
                break;
            end
            next_y = scaled_product(x + x, y) + c_im;
            x      = xx - yy + c_re;
            y      = next_y;
            count++;
        end
        return (count == limit);
    endfunction

    // The result word is checked before a new command is taken, since a
    // command may be accepted in the very cycle that a result is shown.
    always @(posedge i_clk) begin
        t_pixel_verdict awaited;
        t_pixel_verdict predicted;
        if (!i_rst_n) begin
            awaited_verdicts.delete();
            iter_limit   = MAX_ITER_RESET;
            o_fail_count = 0;
            o_pixels     = 0;
            o_results    = 0;
            o_inside     = 0;
        end else begin
            if (i_result_valid) begin
                o_results++;
                if (i_in_set) begin
                    o_inside++;
                end
                if (awaited_verdicts.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with none expected: row %0d col %0d in_set %0d",
                             $realtime, i_row_out, i_col_out, i_in_set);
                end else begin
                    awaited = awaited_verdicts.pop_front();
                    if (awaited.row !== i_row_out) begin
                        o_fail_count++;
                        $display("%0t: row_out mismatch: expected %0d, got %0d",
                                 $realtime, awaited.row, i_row_out);
                    end
                    if (awaited.col !== i_col_out) begin
                        o_fail_count++;
                        $display("%0t: col_out mismatch: expected %0d, got %0d",
                                 $realtime, awaited.col, i_col_out);
                    end
                    if (awaited.in_set !== i_in_set) begin
                        o_fail_count++;
                        $display("%0t: in_set mismatch at row %0d col %0d: expected %0d, got %0d",
                                 $realtime, awaited.row, awaited.col, awaited.in_set,
                                 i_in_set);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                iter_limit = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                o_pixels++;
                predicted.row    = i_row;
                predicted.col    = i_col;
                predicted.in_set = stays_bounded(i_row, i_col, iter_limit);
                awaited_verdicts.push_back(predicted);
            end
        end
        o_pending = awaited_verdicts.size();
    end

endmodule

// ===== tb/mandelbrot_membership_test_tb.sv =====
`timescale 1ns / 1ps

module mandelbrot_membership_test_tb;

    // Local names for the shared widths and image size.
    localparam int unsigned ROW_W        = mbrot_pkg::ROW_W;
    localparam int unsigned COL_W        = mbrot_pkg::COL_W;
    localparam int unsigned ITER_W       = mbrot_pkg::ITER_W;
    localparam int unsigned IMAGE_WIDTH  = mbrot_pkg::IMAGE_WIDTH;
    localparam int unsigned IMAGE_HEIGHT = mbrot_pkg::IMAGE_HEIGHT;

    localparam int unsigned FRACTION_BITS = 28;
    // The slowest pixel issued is one inside the set at a limit of 1000;
    // the watchdog allows several times the run of that pixel.
    localparam int unsigned QUIET_LIMIT   = 60000;
    localparam int unsigned DRAIN_CYCLES  = 64;
    localparam int          RAND_PHASES   = 5;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [ROW_W-1:0]      i_row       = '0;
    logic [COL_W-1:0]      i_col       = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [ITER_W-1:0]     i_cfg_data  = '0;
    logic                  busy;
    logic                  o_result_valid;
    logic [ROW_W-1:0]      o_row_out;
    logic [COL_W-1:0]      o_col_out;
    logic                  o_in_set;
    logic                  o_cfg_ready;

    int unsigned           fail_count;
    int unsigned           pending;
    int unsigned           pixels_taken;
    int unsigned           results_seen;
    int unsigned           inside_seen;
    int unsigned           limit_settings = 0;
    int unsigned           quiet_cycles   = 0;

    // Random phases: sender idle percentage, iteration limit and pixel count.
    int unsigned           phase_idle [RAND_PHASES] = '{0, 88, 30, 0, 30};
    int unsigned           phase_limit[RAND_PHASES] = '{24, 100, 300, 2, 1000};
    int unsigned           phase_count[RAND_PHASES] = '{150, 150, 150, 110, 40};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mandelbrot_membership_test #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_row(i_row),
        .i_col(i_col),
        .o_result_valid(o_result_valid),
        .o_row_out(o_row_out),
        .o_col_out(o_col_out),
        .o_in_set(o_in_set),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    mandelbrot_membership_test_checker #(
        .FRACTION_BITS(FRACTION_BITS)
    ) chk (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_row(i_row),
        .i_col(i_col),
        .i_result_valid(o_result_valid),
        .i_row_out(o_row_out),
        .i_col_out(o_col_out),
        .i_in_set(o_in_set),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_pixels(pixels_taken),
        .o_results(results_seen),
        .o_inside(inside_seen)
    );

    // Watchdog: any accepted word on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one pixel after a random gap and returns at the falling edge
    // after it was taken, with start still high so that a following pixel
    // can go straight on.
    task automatic drive_pixel(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                               input int unsigned idle_pct);
        logic taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_row <= row;
        i_col <= col;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end while (!taken);
    endtask

    // Mostly pixels inside the image, some anywhere in the field range.
    task automatic drive_random_pixel(input int unsigned idle_pct);
        if ($urandom_range(9) == 0) begin
            drive_pixel(ROW_W'($urandom_range(2**ROW_W - 1)),
                        COL_W'($urandom_range(2**COL_W - 1)), idle_pct);
        end else begin
            drive_pixel(ROW_W'($urandom_range(IMAGE_HEIGHT - 1)),
                        COL_W'($urandom_range(IMAGE_WIDTH - 1)), idle_pct);
        end
    endtask

    // Drops start and waits until every pixel issued has come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Writes the iteration limit once the block is idle.
    task automatic write_limit(input logic [ITER_W-1:0] limit);
        logic taken;
        wait_idle();
        i_cfg_data  <= limit;
        i_cfg_valid <= 1'b1;
        do begin
            @(posedge i_clk);
            taken = o_cfg_ready;
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset limit: image corners, far off the image, and one point deep in the set.
        drive_pixel('0, '0, 0);
        drive_pixel(ROW_W'(IMAGE_HEIGHT - 1), COL_W'(IMAGE_WIDTH - 1), 0);
        drive_pixel('0, COL_W'(IMAGE_WIDTH - 1), 0);
        drive_pixel(ROW_W'(IMAGE_HEIGHT - 1), '0, 0);
        drive_pixel(ROW_W'(400), COL_W'(1000), 0);
        drive_pixel('1, '1, 0);

        // A limit of zero does no iteration, so every pixel counts as inside.
        write_limit('0);
        drive_pixel(ROW_W'(400), COL_W'(1000), 0);
        drive_pixel('0, '0, 0);
        drive_pixel('1, '1, 0);

        // A single iteration never escapes from zero.
        write_limit(ITER_W'(1));
        drive_pixel('0, '0, 0);
        drive_pixel(ROW_W'(512), COL_W'(1024), 0);
        drive_pixel('1, '1, 0);

        // Largest limit, only with points that escape within a few steps.
        write_limit(16'hFFFF);
        drive_pixel('0, '0, 0);
        drive_pixel(ROW_W'(IMAGE_HEIGHT - 1), COL_W'(IMAGE_WIDTH - 1), 0);
        drive_pixel('0, COL_W'(IMAGE_WIDTH - 1), 0);
        drive_pixel('1, COL_W'(1024), 0);
        drive_pixel(ROW_W'(512), '1, 0);
        drive_pixel('1, '1, 0);

        // Random pixels under several limits and sender idling patterns.
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_limit(ITER_W'(phase_limit[p]));
            for (int n = 0; n < phase_count[p]; n++) begin
                drive_random_pixel(phase_idle[p]);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d pixels, %0d results (%0d inside the set), %0d limit settings",
                 pixels_taken, results_seen, inside_seen, limit_settings);
        $display("Limits ranged from 0 to 65535; sender idle 0, 30 and 88 percent.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
